FILE: hdl/lsal_pkg.sv
package lsal_pkg;

    localparam int unsigned CH_W = 16;
    localparam logic [CH_W-1:0] LOW_THRESHOLD  = 16'd1000;
    localparam logic [CH_W-1:0] HIGH_THRESHOLD = 16'd20000;
    localparam logic [CH_W-1:0] CH_FULL        = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_AUTO  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_TIME  = 2'd2;
    localparam logic [1:0] REG_GLASS = 2'd3;

    // Numerator width: 16-bit glass factor times a raw value below 2^33.
    localparam int unsigned RAW_W = 34;
    localparam int unsigned NUM_W = 50;
    localparam int unsigned DEN_W = 29;
    localparam int unsigned CNT_W = 6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SATURATED = 3'd1,
        ST_BLACKOUT  = 3'd2,
        ST_RATIO     = 3'd3,
        ST_RESERVED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DEN,
        S_DIV,
        S_OUT
    } ctrl_state_t;

    typedef enum logic {
        KIND_RECONF = 1'b0,
        KIND_MEAS   = 1'b1
    } kind_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture sample and compute raw value
        logic mul;      // form numerator
        logic den;      // form denominator and clear divider
        logic div_step; // one restoring division step
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    function automatic logic [6:0] gain_mult(input logic [2:0] g);
        case (g)
            3'd0:    gain_mult = 7'd1;
            3'd1:    gain_mult = 7'd2;
            3'd2:    gain_mult = 7'd4;
            3'd3:    gain_mult = 7'd8;
            3'd6:    gain_mult = 7'd48;
            3'd7:    gain_mult = 7'd96;
            default: gain_mult = 7'd0;
        endcase
    endfunction

    function automatic logic [8:0] time_ms(input logic [2:0] t);
        case (t)
            3'd0:    time_ms = 9'd100;
            3'd1:    time_ms = 9'd50;
            3'd2:    time_ms = 9'd200;
            3'd3:    time_ms = 9'd400;
            3'd4:    time_ms = 9'd150;
            3'd5:    time_ms = 9'd250;
            3'd6:    time_ms = 9'd300;
            default: time_ms = 9'd350;
        endcase
    endfunction

    // Gain ranging order 0,1,2,3,6,7; reserved codes never move.
    function automatic logic [2:0] gain_step(input logic [2:0] g, input logic up);
        case (g)
            3'd0:    gain_step = up ? 3'd1 : 3'd0;
            3'd1:    gain_step = up ? 3'd2 : 3'd0;
            3'd2:    gain_step = up ? 3'd3 : 3'd1;
            3'd3:    gain_step = up ? 3'd6 : 3'd2;
            3'd6:    gain_step = up ? 3'd7 : 3'd3;
            3'd7:    gain_step = up ? 3'd7 : 3'd6;
            default: gain_step = g;
        endcase
    endfunction

    // Time ranging order 1,0,4,2,5,6,7,3.
    function automatic logic [2:0] time_step(input logic [2:0] t, input logic up);
        case (t)
            3'd1:    time_step = up ? 3'd0 : 3'd1;
            3'd0:    time_step = up ? 3'd4 : 3'd1;
            3'd4:    time_step = up ? 3'd2 : 3'd0;
            3'd2:    time_step = up ? 3'd5 : 3'd4;
            3'd5:    time_step = up ? 3'd6 : 3'd2;
            3'd6:    time_step = up ? 3'd7 : 3'd5;
            3'd7:    time_step = up ? 3'd3 : 3'd6;
            default: time_step = up ? 3'd3 : 3'd7;
        endcase
    endfunction

endpackage

FILE: hdl/lsal_datapath.sv
module lsal_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lsal_pkg::dp_cmd_t         cmd,
    output lsal_pkg::dp_stat_t        stat,
    input  logic [15:0]               ch0,
    input  logic [15:0]               ch1,
    input  logic [2:0]                gain,
    input  logic [2:0]                tcode,
    input  logic [15:0]               glass,
    output logic [2:0]                status,
    output logic [31:0]               lux
);
    import lsal_pkg::*;

    logic [RAW_W-1:0] raw_reg;
    logic [2:0]       status_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [17:0]      dmul_reg;

    logic [17:0] sum;
    logic [23:0] r100, s45, s64, s85;
    logic [RAW_W:0] raw_c;
    logic [2:0]  status_c;
    logic [DEN_W:0] rem_sh;

    // Ratio band compares and the signed band formula.
    always_comb begin
        sum  = 18'(ch0) + 18'(ch1);
        r100 = 24'(ch1) * 24'd100;
        s45  = 24'(sum) * 24'd45;
        s64  = 24'(sum) * 24'd64;
        s85  = 24'(sum) * 24'd85;
        raw_c = '0;
        status_c = ST_OK;
        if (ch0 == CH_FULL || ch1 == CH_FULL) begin
            status_c = ST_SATURATED;
        end else if (ch0 == '0 && ch1 == '0) begin
            status_c = ST_BLACKOUT;
        end else if (r100 < s45) begin
            raw_c = (RAW_W+1)'(ch0) * 35'd17743 + (RAW_W+1)'(ch1) * 35'd11059;
        end else if (r100 < s64) begin
            raw_c = (RAW_W+1)'(ch0) * 35'd42785 - (RAW_W+1)'(ch1) * 35'd19548;
        end else if (r100 < s85) begin
            raw_c = (RAW_W+1)'(ch0) * 35'd5926 + (RAW_W+1)'(ch1) * 35'd1185;
        end else begin
            status_c = ST_RATIO;
        end
        if (status_c == ST_OK && gain_mult(gain) == '0) begin
            status_c = ST_RESERVED;
        end
        // Negative results and non-OK statuses clamp the raw value to zero.
        if (status_c != ST_OK || raw_c[RAW_W]) begin
            raw_c = '0;
        end
    end

    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};

    // Operand registers and the restoring divider.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_reg    <= raw_c[RAW_W-1:0];
            status_reg <= status_c;
        end
        if (cmd.mul) begin
            num_reg  <= NUM_W'(raw_reg) * NUM_W'(glass);
            dmul_reg <= 18'(gain_mult(gain)) * 18'd1600;
        end
        if (cmd.den) begin
            den_reg <= DEN_W'(dmul_reg) * DEN_W'(time_ms(tcode));
            quo_reg <= num_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Step counter for the division.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.den) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign stat.div_done = (cnt_reg == CNT_W'(NUM_W - 1)) && cmd.div_step;
    assign status = status_reg;
    assign lux = (status_reg != ST_OK) ? 32'd0 :
                 (|quo_reg[NUM_W-1:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];

endmodule

FILE: hdl/lsal_ctrl.sv
module lsal_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                func,
    input  logic [15:0]         ch0,
    input  logic                auto_mode,
    input  logic [2:0]          start_gain,
    input  logic [2:0]          start_time,
    input  logic                out_taken,
    input  lsal_pkg::dp_stat_t  stat,
    output lsal_pkg::dp_cmd_t   cmd,
    output logic                s_ready_o,
    output logic                m_valid_o,
    output logic                kind,
    output logic [2:0]          gain,
    output logic [2:0]          tcode,
    output logic                cap_en
);
    import lsal_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic busy_reg, busy_next;
    logic [2:0] gain_reg, gain_next, time_reg, time_next;
    logic kind_reg, kind_next;
    logic out_v_reg, out_v_next;
    logic up, range;
    logic [2:0] ng, nt;

    // Ranging decision for the current sample.
    always_comb begin
        up    = ch0 <= LOW_THRESHOLD;
        range = auto_mode && (up || ch0 >= HIGH_THRESHOLD);
        ng    = gain_step(gain_reg, up);
        nt    = (ng == gain_reg) ? time_step(time_reg, up) : time_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        gain_next  = gain_reg;
        time_next  = time_reg;
        kind_next  = kind_reg;
        out_v_next = out_v_reg && !out_taken;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (!func) begin
                        if (!busy_reg) begin
                            gain_next = start_gain;
                            time_next = start_time;
                            busy_next = 1'b1;
                            if (auto_mode) begin
                                kind_next  = KIND_RECONF;
                                state_next = S_OUT;
                            end
                        end
                    end else if (busy_reg) begin
                        if (range && (ng != gain_reg || nt != time_reg)) begin
                            gain_next  = ng;
                            time_next  = nt;
                            kind_next  = KIND_RECONF;
                            state_next = S_OUT;
                        end else begin
                            busy_next  = 1'b0;
                            kind_next  = KIND_MEAS;
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL: state_next = S_DEN;
            S_DEN: state_next = S_DIV;
            S_DIV: if (stat.div_done) state_next = S_OUT;
            S_OUT: begin
                if (!out_v_reg || out_taken) begin
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_fire;
        cmd.mul      = (state_reg == S_MUL);
        cmd.den      = (state_reg == S_DEN);
        cmd.div_step = (state_reg == S_DIV);
        s_ready_o    = (state_reg == S_IDLE);
        cap_en       = (state_reg == S_OUT) && (!out_v_reg || out_taken);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            gain_reg  <= '0;
            time_reg  <= '0;
            kind_reg  <= KIND_RECONF;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            gain_reg  <= gain_next;
            time_reg  <= time_next;
            kind_reg  <= kind_next;
            out_v_reg <= out_v_next;
        end
    end

    assign m_valid_o = out_v_reg;
    assign kind  = kind_reg;
    assign gain  = gain_reg;
    assign tcode = time_reg;

endmodule

FILE: hdl/light_sensor_autorange_lux.sv
// Channel  | Handshake            | Payload
// s_       | s_valid / s_ready    | s_func, s_visible_ir_count, s_ir_count
// m_       | m_valid / m_ready    | m_kind, m_gain_code, m_time_code, m_status,
//          |                      | m_lux, m_visible_ir_out, m_ir_out
// cfg_     | cfg_we               | cfg_index, cfg_wdata
//
// A start request in auto mode or a reconfiguring sample passes through the output
// state; a manual start or an ignored request leaves the block idle. A measuring
// sample goes through capture, two multiply stages, a 50-step restoring divider and
// the output load. The result sits in an output register, so the block returns to
// accepting input while it waits for m_ready; the next result holds the input off
// until that register frees. Reset is synchronous on aresetn (active low).
module light_sensor_autorange_lux (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_visible_ir_count,
    input  logic [15:0] s_ir_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_gain_code,
    output logic [2:0]  m_time_code,
    output logic [2:0]  m_status,
    output logic [31:0] m_lux,
    output logic [15:0] m_visible_ir_out,
    output logic [15:0] m_ir_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import lsal_pkg::*;

    logic        auto_reg;
    logic [2:0]  sgain_reg, stime_reg;
    logic [15:0] glass_reg;
    logic [15:0] ch0_reg, ch1_reg;
    logic        in_fire, out_taken, cap_en, kind;
    logic [2:0]  gain, tcode, status;
    logic [31:0] lux;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign in_fire   = s_valid && s_ready;
    assign out_taken = m_valid && m_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg  <= 1'b0;
            sgain_reg <= '0;
            stime_reg <= '0;
            glass_reg <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_AUTO:  auto_reg  <= cfg_wdata[0];
                REG_GAIN:  sgain_reg <= cfg_wdata[2:0];
                REG_TIME:  stime_reg <= cfg_wdata[2:0];
                REG_GLASS: glass_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sample counts held for the measurement.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ch0_reg <= s_visible_ir_count;
            ch1_reg <= s_ir_count;
        end
    end

    lsal_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .func(s_func),
        .ch0(s_visible_ir_count), .auto_mode(auto_reg), .start_gain(sgain_reg),
        .start_time(stime_reg), .out_taken(out_taken), .stat(stat), .cmd(cmd),
        .s_ready_o(s_ready), .m_valid_o(m_valid), .kind(kind), .gain(gain),
        .tcode(tcode), .cap_en(cap_en)
    );

    lsal_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .ch0(s_visible_ir_count), .ch1(s_ir_count), .gain(gain), .tcode(tcode),
        .glass(glass_reg), .status(status), .lux(lux)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (cap_en) begin
            m_kind      <= kind;
            m_gain_code <= gain;
            m_time_code <= tcode;
            if (kind == KIND_MEAS) begin
                m_status         <= status;
                m_lux            <= lux;
                m_visible_ir_out <= ch0_reg;
                m_ir_out         <= ch1_reg;
            end else begin
                m_status         <= ST_OK;
                m_lux            <= '0;
                m_visible_ir_out <= '0;
                m_ir_out         <= '0;
            end
        end
    end

endmodule
